// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on i_clk, held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true implies cons in the same cycle
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true implies cons in the next cycle
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/anbsf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anbsf_pkg
// Types, constants and NAL header helpers for the Annex-B NAL splitter.
// ---------------------------------------------------------------------------
package anbsf_pkg;

    localparam int MAX_RES    = 5;               // results one word can cause
    localparam int NRES_W     = $clog2(MAX_RES + 1);
    localparam int HOLD_DEPTH = 4;
    localparam int HC_W       = $clog2(HOLD_DEPTH + 1);
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    localparam logic [1:0] ROUTE_VPS = 2'd0;
    localparam logic [1:0] ROUTE_SPS = 2'd1;
    localparam logic [1:0] ROUTE_PPS = 2'd2;
    localparam logic [1:0] ROUTE_FWD = 2'd3;    // also "no parameter role"

    localparam logic [5:0] H264_SEI   = 6'd6;
    localparam logic [5:0] H264_SPS   = 6'd7;
    localparam logic [5:0] H264_PPS   = 6'd8;
    localparam logic [5:0] H265_VPS   = 6'd32;
    localparam logic [5:0] H265_SPS   = 6'd33;
    localparam logic [5:0] H265_PPS   = 6'd34;
    localparam logic [5:0] H265_SEI_P = 6'd39;
    localparam logic [5:0] H265_SEI_S = 6'd40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [5:0] nal_type;
        logic [1:0] route;
        logic       nal_first;
        logic       nal_last;
        logic       params_due;
        logic       run_last;
    } t_res;

    function automatic logic [5:0] nal_type_of(input logic mode, input logic [7:0] hdr);
        return (mode == CODEC_H265) ? hdr[6:1] : {1'b0, hdr[4:0]};
    endfunction

    function automatic logic [1:0] param_role(input logic mode, input logic [5:0] t);
        logic [1:0] r;
        r = ROUTE_FWD;
        if (mode == CODEC_H265) begin
            if (t == H265_VPS) r = ROUTE_VPS;
            if (t == H265_SPS) r = ROUTE_SPS;
            if (t == H265_PPS) r = ROUTE_PPS;
        end else begin
            if (t == H264_SPS) r = ROUTE_SPS;
            if (t == H264_PPS) r = ROUTE_PPS;
        end
        return r;
    endfunction

    function automatic logic not_forwarded(input logic mode, input logic [5:0] t);
        if (mode == CODEC_H265)
            return (t == H265_VPS) || (t == H265_SPS) || (t == H265_PPS) ||
                   (t == H265_SEI_P) || (t == H265_SEI_S);
        return (t == H264_SEI) || (t == H264_SPS) || (t == H264_PPS);
    endfunction

endpackage

// ===== src/annexb_nal_splitter_filter.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// annexb_nal_splitter_filter
// Splits an Annex-B byte stream into NAL units, strips start codes and
// routes parameter sets to capture or units to the muxer.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_stall    i_in_byte, i_packet_end
//  out       source     o_out_valid / i_out_stall  o_out_byte .. o_run_last
//  cfg       sink       i_cfg_we                   i_cfg_wdata (codec mode)
//
//  One input word per cycle unless stalled; accepted words are registered first.
//  A word emits 0 to 5 results into an 8-entry result queue, read out one per
//  unstalled output cycle; input stalls if a word waits and over 3 are queued.
//  Synchronous active-low reset clears control state only; no clearing pass.
//  Output payload comes straight from the queue head and holds under stall.
// ---------------------------------------------------------------------------
module annexb_nal_splitter_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_packet_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [5:0] o_nal_type,
    output logic [1:0] o_route,
    output logic       o_nal_first,
    output logic       o_nal_last,
    output logic       o_params_due,
    output logic       o_run_last
);
    import anbsf_pkg::*;

    logic              r_mode;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;

    logic [7:0]        r_hold [HOLD_DEPTH];
    logic [HC_W-1:0]   r_hc;
    logic              r_inside;
    logic              r_hdr_pend;
    logic [5:0]        r_type;
    logic [1:0]        r_route;
    logic              r_kept;
    logic              r_have_sps;
    logic              r_have_pps;
    logic              r_ready;
    logic              r_sent;

    t_res              r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    logic              w_go;
    logic              w_accept;
    logic              w_pop;

    logic              hdr_take;
    logic [5:0]        e_type;
    logic [1:0]        e_route;
    logic [1:0]        e_role;
    logic              e_kept;
    logic              e_sps;
    logic              e_pps;
    logic              e_ready;
    logic              is_end;
    logic              is_sc;
    logic              three_zero;
    logic [HC_W-1:0]   content;
    logic              emit_ok;
    logic [NRES_W-1:0] n_res;
    logic [7:0]        ext [MAX_RES];
    t_res              res [MAX_RES];
    logic              n_sent;

    // queue leaves room for a worst-case word before the step runs
    assign w_go       = r_in_valid && (r_cnt <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign o_in_stall = r_in_valid && !w_go;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign w_pop      = o_out_valid && !i_out_stall;

    always_comb begin
        hdr_take = r_inside && (r_hc == '0);
        e_type   = r_type;
        e_route  = r_route;
        e_kept   = r_kept;
        e_sps    = r_have_sps;
        e_pps    = r_have_pps;
        e_ready  = r_ready;
        e_role   = param_role(r_mode, nal_type_of(r_mode, r_in_byte));
        if (hdr_take) begin
            e_type  = nal_type_of(r_mode, r_in_byte);
            e_route = ROUTE_FWD;
            e_kept  = 1'b0;
            if (!r_ready) begin
                if (e_role != ROUTE_FWD) begin
                    e_route = e_role;
                    e_kept  = 1'b1;
                    if (e_role == ROUTE_SPS) e_sps = 1'b1;
                    if (e_role == ROUTE_PPS) e_pps = 1'b1;
                    e_ready = e_sps && e_pps;
                end
            end else begin
                e_kept = !not_forwarded(r_mode, e_type);
            end
        end

        // start code ends on this 01 byte; the two or three zeros are held
        is_end = r_in_end;
        is_sc  = !r_in_end && (r_in_byte == 8'h01) &&
                 (((r_hc == HC_W'(2)) && (r_hold[0] == 8'h00) && (r_hold[1] == 8'h00)) ||
                  ((r_hc == HC_W'(3)) && (r_hold[1] == 8'h00) && (r_hold[2] == 8'h00)) ||
                  ((r_hc == HC_W'(4)) && (r_hold[2] == 8'h00) && (r_hold[3] == 8'h00)));
        three_zero = ((r_hc == HC_W'(3)) && (r_hold[0] == 8'h00)) ||
                     ((r_hc == HC_W'(4)) && (r_hold[1] == 8'h00));
        content = r_hc - (three_zero ? HC_W'(3) : HC_W'(2));

        emit_ok = r_inside && e_kept;
        n_res   = '0;
        if (emit_ok) begin
            priority if (is_end)
                n_res = NRES_W'(r_hc) + NRES_W'(1);
            else if (is_sc)
                n_res = NRES_W'(content);
            else if (r_hc == HC_W'(HOLD_DEPTH))
                n_res = NRES_W'(1);
        end

        for (int j = 0; j < HOLD_DEPTH; j++) ext[j] = r_hold[j];
        ext[MAX_RES-1] = r_in_byte;
        for (int j = 0; j < MAX_RES; j++) begin
            res[j].out_byte   = (HC_W'(j) < r_hc) ? ext[j] : r_in_byte;
            res[j].nal_type   = e_type;
            res[j].route      = e_route;
            res[j].nal_first  = (j == 0) && r_hdr_pend;
            res[j].run_last   = (NRES_W'(j + 1) == n_res);
            res[j].nal_last   = (is_end || is_sc) && (NRES_W'(j + 1) == n_res);
            res[j].params_due = (e_route == ROUTE_FWD) && !r_sent;
        end

        n_sent = r_sent ||
                 (emit_ok && (e_route == ROUTE_FWD) &&
                  (is_end || (is_sc && (content != '0))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= CODEC_H264;
            r_in_valid <= 1'b0;
            r_hc       <= '0;
            r_inside   <= 1'b0;
            r_hdr_pend <= 1'b0;
            r_type     <= '0;
            r_route    <= ROUTE_VPS;
            r_kept     <= 1'b0;
            r_have_sps <= 1'b0;
            r_have_pps <= 1'b0;
            r_ready    <= 1'b0;
            r_sent     <= 1'b0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;

            if (w_accept)  r_in_valid <= 1'b1;
            else if (w_go) r_in_valid <= 1'b0;

            if (w_go) begin
                r_type     <= e_type;
                r_route    <= e_route;
                r_kept     <= e_kept;
                r_have_sps <= e_sps;
                r_have_pps <= e_pps;
                r_ready    <= e_ready;
                r_sent     <= n_sent;
                priority if (is_end) begin
                    r_hc       <= '0;
                    r_inside   <= 1'b0;
                    r_hdr_pend <= 1'b0;
                end else if (is_sc) begin
                    r_hc       <= '0;
                    r_inside   <= 1'b1;
                    r_hdr_pend <= 1'b1;
                end else begin
                    if (r_hc == HC_W'(HOLD_DEPTH)) begin
                        if (r_inside) r_hdr_pend <= 1'b0;
                    end else begin
                        r_hc <= r_hc + HC_W'(1);
                    end
                end
            end

            if (w_go) r_wptr <= r_wptr + PTR_W'(n_res);
            if (w_pop) r_rptr <= r_rptr + PTR_W'(1);
            r_cnt <= r_cnt + (w_go ? CNT_W'(n_res) : CNT_W'(0)) - (w_pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_packet_end;
        end
        if (w_go && !is_end && !is_sc) begin
            if (r_hc == HC_W'(HOLD_DEPTH)) begin
                for (int k = 0; k < HOLD_DEPTH - 1; k++) r_hold[k] <= r_hold[k+1];
                r_hold[HOLD_DEPTH-1] <= r_in_byte;
            end else begin
                r_hold[r_hc[HC_W-2:0]] <= r_in_byte;
            end
        end
        for (int j = 0; j < MAX_RES; j++) begin
            if (w_go && (NRES_W'(j) < n_res)) r_fifo[r_wptr + PTR_W'(j)] <= res[j];
        end
    end

    assign o_out_byte   = r_fifo[r_rptr].out_byte;
    assign o_nal_type   = r_fifo[r_rptr].nal_type;
    assign o_route      = r_fifo[r_rptr].route;
    assign o_nal_first  = r_fifo[r_rptr].nal_first;
    assign o_nal_last   = r_fifo[r_rptr].nal_last;
    assign o_params_due = r_fifo[r_rptr].params_due;
    assign o_run_last   = r_fifo[r_rptr].run_last;

    `AST_IMP(a_no_overflow, w_go, (r_cnt + CNT_W'(n_res)) <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `AST_IMP(a_hdr_inside, r_hdr_pend, r_inside, "header pending outside a unit")
    `AST_IMP(a_ready_both, r_ready, r_have_sps && r_have_pps, "params ready without SPS and PPS")
    `AST_NEXT(a_sent_after_ready, r_sent, r_sent && r_ready, "params sent before ready")

endmodule

// ===== sim/annexb_nal_splitter_filter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// annexb_nal_splitter_filter_tb
// Feeds Annex-B packets (directed start-code cases, then random packets
// built mostly from well-formed NAL units) into the splitter. It predicts
// every emitted NAL byte and checks each one in order against the output.
// Both sides idle at random, and one phase holds off the output to back
// up the input. The codec mode is switched between drained phases.
// ---------------------------------------------------------------------------
module annexb_nal_splitter_filter_tb;
    import anbsf_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       pend;
        int         gap;
    } t_stream_word;

    typedef logic [7:0] t_byte_list[$];

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_end = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    t_res       got;

    annexb_nal_splitter_filter DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_byte    (in_byte),
        .i_packet_end (in_end),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (got.out_byte),
        .o_nal_type   (got.nal_type),
        .o_route      (got.route),
        .o_nal_first  (got.nal_first),
        .o_nal_last   (got.nal_last),
        .o_params_due (got.params_due),
        .o_run_last   (got.run_last)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // stimulus and expectations
    t_stream_word word_q[$];
    t_res         nal_byte_q[$];
    t_res         word_results[$];
    logic         codec_sel = CODEC_H264;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;
    int           hold_req = 0;

    int n_queued = 0;
    int n_packets = 0;
    int n_words = 0;
    int n_checked = 0;
    int n_units = 0;
    int errors = 0;

    // shadow of the splitter state
    logic [7:0] held[4];
    int         held_n = 0;
    bit         in_unit = 1'b0;
    bit         hdr_due = 1'b0;
    logic [5:0] unit_type = '0;
    logic [1:0] unit_route = ROUTE_VPS;
    bit         unit_kept = 1'b0;
    bit         got_sps = 1'b0;
    bit         got_pps = 1'b0;
    bit         sets_ready = 1'b0;
    bit         sets_sent = 1'b0;

    // header byte: classify the unit that starts here
    function automatic void open_unit(input logic [7:0] hdr);
        logic [5:0] t;
        logic [1:0] role;
        bit         skip;
        t = (codec_sel == CODEC_H265) ? hdr[6:1] : {1'b0, hdr[4:0]};
        role = ROUTE_FWD;
        if (codec_sel == CODEC_H265) begin
            if (t == H265_VPS) role = ROUTE_VPS;
            if (t == H265_SPS) role = ROUTE_SPS;
            if (t == H265_PPS) role = ROUTE_PPS;
            skip = (role != ROUTE_FWD) || t == H265_SEI_P || t == H265_SEI_S;
        end else begin
            if (t == H264_SPS) role = ROUTE_SPS;
            if (t == H264_PPS) role = ROUTE_PPS;
            skip = (role != ROUTE_FWD) || t == H264_SEI;
        end
        unit_type = t;
        unit_route = ROUTE_FWD;
        unit_kept = 1'b0;
        if (!sets_ready) begin
            if (role != ROUTE_FWD) begin
                unit_route = role;
                unit_kept = 1'b1;
                if (role == ROUTE_SPS) got_sps = 1'b1;
                if (role == ROUTE_PPS) got_pps = 1'b1;
                if (got_sps && got_pps) sets_ready = 1'b1;
            end
        end else if (!skip) begin
            unit_kept = 1'b1;
        end
    endfunction

    function automatic void push_nal_byte(input logic [7:0] b, input bit last);
        t_res r;
        if (unit_kept) begin
            r.out_byte = b;
            r.nal_type = unit_type;
            r.route = unit_route;
            r.nal_first = hdr_due;
            r.nal_last = last;
            r.params_due = (unit_route == ROUTE_FWD) && !sets_sent;
            r.run_last = 1'b0;
            word_results.insert(word_results.size(), r);
            if (last && unit_route == ROUTE_FWD) sets_sent = 1'b1;
        end
        hdr_due = 1'b0;
    endfunction

    // one accepted stream word -> the NAL bytes it releases
    function automatic void split_word(input logic [7:0] b, input logic pend);
        int zeros;
        int n_body;
        word_results.delete();
        if (in_unit && held_n == 0) open_unit(b);
        if (pend) begin
            if (in_unit) begin
                for (int i = 0; i < held_n; i++) push_nal_byte(held[i], 1'b0);
                push_nal_byte(b, 1'b1);
            end
            held_n = 0;
            in_unit = 1'b0;
            hdr_due = 1'b0;
        end else if (b == 8'h01 && held_n >= 2 && held[held_n - 1] == 8'h00 &&
                     held[held_n - 2] == 8'h00) begin
            // only the last two or three zeros belong to the start code
            zeros = (held_n >= 3 && held[held_n - 3] == 8'h00) ? 3 : 2;
            n_body = held_n - zeros;
            if (in_unit)
                for (int i = 0; i < n_body; i++) push_nal_byte(held[i], i + 1 == n_body);
            held_n = 0;
            in_unit = 1'b1;
            hdr_due = 1'b1;
        end else begin
            if (held_n == 4) begin
                if (in_unit) push_nal_byte(held[0], 1'b0);
                held[0] = held[1];
                held[1] = held[2];
                held[2] = held[3];
                held_n--;
            end
            held[held_n] = b;
            held_n++;
        end
        if (word_results.size() > 0) word_results[$].run_last = 1'b1;
        foreach (word_results[i]) nal_byte_q.insert(nal_byte_q.size(), word_results[i]);
    endfunction

    function automatic string res_str(input t_res r);
        return $sformatf("byte=%02h type=%0d route=%0d first=%0b last=%0b due=%0b rl=%0b",
                         r.out_byte, r.nal_type, r.route, r.nal_first, r.nal_last,
                         r.params_due, r.run_last);
    endfunction

    // sender
    always @(posedge clk) begin : drive
        t_stream_word w;
        int           tx_wait;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (in_valid && !in_stall) begin
                split_word(in_byte, in_end);
                n_words++;
            end
            if (!in_valid || !in_stall) begin
                if (word_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (tx_wait < word_q[0].gap) begin
                    tx_wait++;
                    in_valid <= 1'b0;
                end else begin
                    w = word_q[0];
                    word_q.delete(0);
                    tx_wait = 0;
                    in_valid <= 1'b1;
                    in_byte <= w.b;
                    in_end <= w.pend;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin : receive
        t_res want;
        int   rx_wait;
        int   hold_left;
        int   hold_seen;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (nal_byte_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected NAL byte: %s", $time, res_str(got));
                end else begin
                    want = nal_byte_q[0];
                    nal_byte_q.delete(0);
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: NAL byte %0d mismatch", $time, n_checked);
                            $display("    want %s", res_str(want));
                            $display("    got  %s", res_str(got));
                        end
                    end
                end
                n_checked++;
                if (got.nal_last) n_units++;
                rx_wait = rx_idle_en ? $urandom_range(0, 18) : 0;
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic add_word(input logic [7:0] b, input logic pend);
        t_stream_word w;
        w.b = b;
        w.pend = pend;
        w.gap = tx_idle_en ? $urandom_range(0, 18) : 0;
        word_q.insert(word_q.size(), w);
        n_queued++;
    endtask

    task automatic send_packet(input t_byte_list bs);
        foreach (bs[i]) add_word(bs[i], i == bs.size() - 1);
        n_packets++;
    endtask

    function automatic logic [7:0] body_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] header_byte();
        logic [5:0] t;
        logic [7:0] r;
        r = 8'($urandom);
        if (codec_sel == CODEC_H265) begin
            case ($urandom_range(0, 9))
                0: t = H265_VPS;
                1: t = H265_SPS;
                2: t = H265_PPS;
                3: t = H265_SEI_P;
                4: t = H265_SEI_S;
                5: t = 6'($urandom_range(6, 8));
                6: t = 6'd19;
                7: t = 6'd1;
                default: t = 6'($urandom_range(0, 63));
            endcase
            return {r[7], t, r[0]};
        end
        case ($urandom_range(0, 7))
            0: t = H264_SPS;
            1: t = H264_PPS;
            2: t = H264_SEI;
            3: t = 6'd5;
            4: t = 6'd1;
            default: t = 6'($urandom_range(0, 31));
        endcase
        return {r[7:5], t[4:0]};
    endfunction

    // mostly well-formed packets with random content, some noise
    task automatic add_random_packet();
        t_byte_list pkt;
        int         n_zero;
        int         n_body;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                pkt.insert(pkt.size(), ($urandom_range(0, 4) == 0) ? 8'h01 : body_byte());
        end else begin
            if ($urandom_range(0, 4) == 0) pkt.insert(pkt.size(), body_byte());
            repeat ($urandom_range(1, 3)) begin
                n_zero = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(2, 3);
                repeat (n_zero) pkt.insert(pkt.size(), 8'h00);
                pkt.insert(pkt.size(), 8'h01);
                if ($urandom_range(0, 9) != 0) begin
                    pkt.insert(pkt.size(), header_byte());
                    n_body = $urandom_range(0, 5);
                    repeat (n_body) pkt.insert(pkt.size(), body_byte());
                end
            end
        end
        send_packet(pkt);
    endtask

    task automatic add_random(input int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) add_random_packet();
    endtask

    // all words taken, all results seen, then let the pipeline settle
    task automatic drain();
        do @(negedge clk); while (word_q.size() != 0 || in_valid || nal_byte_q.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_codec(input logic m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        codec_sel = m;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_codec(CODEC_H264);

        // leading junk, SPS captured, long zero run, SEI dropped, code at packet end
        send_packet('{8'hAA, 8'h00, 8'h00, 8'h01, 8'h67, 8'h11, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h01, 8'h06, 8'h00, 8'h00, 8'h01});
        @(negedge clk);
        drain();
        set_codec(CODEC_H265);
        // VPS, empty unit, PPS completes the sets, type 6 forwarded with tail code
        send_packet('{8'h00, 8'h00, 8'h01, 8'h40, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                      8'h01, 8'h44, 8'h00, 8'h00, 8'h01, 8'h0C, 8'hFF, 8'h00, 8'h00,
                      8'h01});
        @(negedge clk);
        drain();

        add_random(100);
        @(negedge clk);
        drain();

        // back-to-back words against a long output hold-off
        set_codec(CODEC_H264);
        @(negedge clk);
        tx_idle_en = 1'b0;
        add_random(60);
        hold_req++;
        drain();

        // no idling on either side
        rx_idle_en = 1'b0;
        add_random(60);
        drain();

        set_codec(CODEC_H265);
        @(negedge clk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        add_random(60);
        drain();

        errors += nal_byte_q.size();
        $display("Sent %0d words in %0d packets across both codec modes and idle patterns;",
                 n_words, n_packets);
        $display("checked %0d NAL bytes forming %0d complete units.", n_checked, n_units);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Timeout with %0d NAL bytes still expected", nal_byte_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
